/* rtl/giim_pkg.sv */
// Shared types and constants for the gradient information image metric.
package giim_pkg;

    localparam int unsigned PIX_W    = 16;
    localparam int unsigned SUM_W    = 38;
    localparam int unsigned LN_W     = 20;
    localparam int unsigned NR_W     = 32;
    localparam int unsigned V_W      = 17;
    localparam int unsigned LX_W     = 33;
    localparam int unsigned Y_W      = 31;
    localparam int unsigned CFG_IW   = 2;
    localparam int unsigned CFG_DW   = 16;

    localparam logic [CFG_IW-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IW-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IW-1:0] REG_GAIN   = 2'd2;
    localparam logic [CFG_IW-1:0] REG_THRESH = 2'd3;

    localparam logic [10:0] RST_WIDTH  = 11'd640;
    localparam logic [12:0] RST_HEIGHT = 13'd480;
    localparam logic [15:0] RST_GAIN   = 16'd1000;
    localparam logic [15:0] RST_THRESH = 16'd3932;

    localparam logic [12:0] MAX_HEIGHT = 13'd4096;
    localparam logic [15:0] LN2_Q16    = 16'd45426;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [V_W-1:0]   V_MAX   = 17'h10000;

    typedef enum logic [4:0] {
        S_IDLE,
        S_READ,
        S_SHIFT,
        S_EVAL_SEL,
        S_GRAD,
        S_SQRT_INIT,
        S_SQRT,
        S_MAP,
        S_NORM_START,
        S_LN_NORM,
        S_LN_SQ,
        S_LN_FIN,
        S_SCALE,
        S_ACC,
        S_DIV_INIT,
        S_DIV,
        S_DIV_FIN,
        S_ADVANCE
    } t_state;

    typedef struct packed {
        logic       accept;
        logic       shift;
        logic [1:0] eidx;
        logic       grad;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       map;
        logic       norm_start;
        logic       ln_norm;
        logic       ln_sq;
        logic       ln_fin;
        logic       scale;
        logic       acc;
        logic       div_init;
        logic       div_step;
        logic       div_fin;
        logic       advance;
    } t_cmd;

    typedef struct packed {
        logic [3:0] eval_mask;
        logic       below;
        logic       lx_top;
        logic       norm_dirty;
        logic       out_free;
    } t_stat;

endpackage

/* rtl/giim_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module giim_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/giim_ctrl.sv */
// Controller state machine sequencing pixel intake, window evaluation and normalization.
module giim_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  giim_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output giim_pkg::t_cmd  o_cmd
);

    import giim_pkg::*;

    t_state     r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic [1:0] r_eidx, n_eidx;
    logic       r_norm, n_norm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_eidx  <= '0;
            r_norm  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_eidx  <= n_eidx;
            r_norm  <= n_norm;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_eidx     = r_eidx;
        n_norm     = r_norm;
        o_cmd      = '0;
        o_cmd.eidx = r_eidx;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_stat.norm_dirty) begin
                    n_state = S_NORM_START;
                end else begin
                    o_in_ready = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.accept = 1'b1;
                        n_state      = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_eidx      = '0;
                n_state     = S_EVAL_SEL;
            end
            S_EVAL_SEL: begin
                if (i_stat.eval_mask[r_eidx]) begin
                    n_state = S_GRAD;
                end else if (r_eidx == 2'd3) begin
                    n_state = S_ADVANCE;
                end else begin
                    n_eidx = r_eidx + 2'd1;
                end
            end
            S_GRAD: begin
                o_cmd.grad = 1'b1;
                n_state    = S_SQRT_INIT;
            end
            S_SQRT_INIT: begin
                o_cmd.sqrt_init = 1'b1;
                n_cnt           = '0;
                n_state         = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_cnt == 6'd15) begin
                    n_state = S_MAP;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_MAP: begin
                o_cmd.map = 1'b1;
                n_norm    = 1'b0;
                n_state   = i_stat.below ? S_ACC : S_LN_NORM;
            end
            S_NORM_START: begin
                o_cmd.norm_start = 1'b1;
                n_norm           = 1'b1;
                n_state          = S_LN_NORM;
            end
            S_LN_NORM: begin
                o_cmd.ln_norm = 1'b1;
                if (i_stat.lx_top) begin
                    n_cnt   = '0;
                    n_state = S_LN_SQ;
                end
            end
            S_LN_SQ: begin
                o_cmd.ln_sq = 1'b1;
                if (r_cnt == 6'd15) begin
                    n_state = S_LN_FIN;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_LN_FIN: begin
                o_cmd.ln_fin = 1'b1;
                n_state      = r_norm ? S_DIV_INIT : S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (r_eidx == 2'd3) begin
                    n_state = S_ADVANCE;
                end else begin
                    n_eidx  = r_eidx + 2'd1;
                    n_state = S_EVAL_SEL;
                end
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == 6'd32) begin
                    n_state = S_DIV_FIN;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_DIV_FIN: begin
                o_cmd.div_fin = 1'b1;
                n_state       = S_IDLE;
            end
            S_ADVANCE: begin
                if (i_stat.out_free) begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/giim_dp.sv */
// Datapath: line stores, window, Sobel, square root, logarithm, divider and frame sum.
module giim_dp #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  giim_pkg::t_cmd                i_cmd,
    output giim_pkg::t_stat               o_stat,
    input  logic [giim_pkg::PIX_W-1:0]    i_pixel,
    input  logic                          i_cfg_we,
    input  logic [giim_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [giim_pkg::CFG_DW-1:0]   i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [giim_pkg::SUM_W-1:0]    o_quality_sum
);

    import giim_pkg::*;

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam logic [12:0] MAXW13 = 13'(MAX_WIDTH);

    logic [10:0]       r_width;
    logic [12:0]       r_height;
    logic [15:0]       r_gain;
    logic [15:0]       r_thresh;
    logic              r_dirty;

    logic [CW-1:0]     r_col;
    logic [11:0]       r_row;
    logic [PIX_W-1:0]  r_pix;
    logic [PIX_W-1:0]  r_win [3][3];

    logic [35:0]       r_gx2, r_gy2;
    logic [31:0]       r_rad;
    logic [15:0]       r_root;
    logic [17:0]       r_rem;

    logic [LX_W-1:0]   r_lx;
    logic [5:0]        r_k;
    logic [Y_W-1:0]    r_y;
    logic [15:0]       r_frac;
    logic [LN_W-1:0]   r_ln;

    logic [LN_W-1:0]   r_dn;
    logic [LN_W-1:0]   r_drem;
    logic [32:0]       r_q;
    logic [NR_W-1:0]   r_nr;

    logic [V_W-1:0]    r_v;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  r_out;
    logic              r_out_valid;

    logic [PIX_W-1:0]  up_rd, mid_rd;

    logic [12:0]       w13, h13;
    logic [CW:0]       eff_w;
    logic [12:0]       eff_h;
    logic [15:0]       gain_eff;
    logic [CW-1:0]     col_in;
    logic [11:0]       row_in;
    logic [CW:0]       c1;
    logic [12:0]       r1;
    logic              col_wrap, frame_end;
    logic              col_end, row_end, e0;

    logic [1:0]        ia, ib, ic, jl, jc, jr;
    logic [17:0]       sum_r, sum_l, sum_b, sum_t;
    logic signed [18:0] gx, gy;
    logic signed [37:0] gx2, gy2;

    logic [19:0]       rem_sh, trial;
    logic              sq_ge;
    logic [16:0]       dlt;
    logic [61:0]       ysq;
    logic [31:0]       ysh;
    logic [20:0]       l2;
    logic [36:0]       lnp;
    logic [20:0]       div_sh;
    logic              div_ge;
    logic [51:0]       scp;
    logic [35:0]       sct;
    logic [SUM_W:0]    acc_s;

    giim_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (i_cmd.shift),
        .i_waddr (r_col),
        .i_wdata (mid_rd),
        .i_raddr (r_col),
        .o_rdata (up_rd)
    );

    giim_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
        .i_clk   (i_clk),
        .i_we    (i_cmd.shift),
        .i_waddr (r_col),
        .i_wdata (r_pix),
        .i_raddr (r_col),
        .o_rdata (mid_rd)
    );

    always_comb begin
        w13 = {2'b00, r_width};
        if (w13 < 13'd3) begin
            w13 = 13'd3;
        end
        if (w13 > MAXW13) begin
            w13 = MAXW13;
        end
        eff_w = w13[CW:0];
        h13   = r_height;
        if (h13 < 13'd3) begin
            h13 = 13'd3;
        end
        if (h13 > MAX_HEIGHT) begin
            h13 = MAX_HEIGHT;
        end
        eff_h    = h13;
        gain_eff = (r_gain == 16'd0) ? 16'd1 : r_gain;
    end

    assign col_in    = ({1'b0, r_col} >= eff_w) ? '0 : r_col;
    assign row_in    = ({1'b0, r_row} >= eff_h) ? '0 : r_row;
    assign c1        = {1'b0, r_col} + 1'b1;
    assign r1        = {1'b0, r_row} + 13'd1;
    assign col_wrap  = (c1 >= eff_w);
    assign frame_end = col_wrap && (r1 >= eff_h);

    assign e0      = (r_col != '0) && (r_row != '0);
    assign col_end = ({1'b0, r_col} == eff_w - 1'b1);
    assign row_end = ({1'b0, r_row} == eff_h - 13'd1);

    always_comb begin
        ia = i_cmd.eidx[1] ? 2'd1 : ((r_row == 12'd1) ? 2'd2 : 2'd0);
        ib = i_cmd.eidx[1] ? 2'd2 : 2'd1;
        ic = i_cmd.eidx[1] ? 2'd1 : 2'd2;
        jl = i_cmd.eidx[0] ? 2'd1 : ((r_col >= CW'(2)) ? 2'd0 : 2'd2);
        jc = i_cmd.eidx[0] ? 2'd2 : 2'd1;
        jr = i_cmd.eidx[0] ? 2'd1 : 2'd2;
        sum_r = 18'(r_win[ia][jr]) + {1'b0, r_win[ib][jr], 1'b0} + 18'(r_win[ic][jr]);
        sum_l = 18'(r_win[ia][jl]) + {1'b0, r_win[ib][jl], 1'b0} + 18'(r_win[ic][jl]);
        sum_b = 18'(r_win[ic][jl]) + {1'b0, r_win[ic][jc], 1'b0} + 18'(r_win[ic][jr]);
        sum_t = 18'(r_win[ia][jl]) + {1'b0, r_win[ia][jc], 1'b0} + 18'(r_win[ia][jr]);
        gx  = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
        gy  = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
        gx2 = gx * gx;
        gy2 = gy * gy;
    end

    always_comb begin
        rem_sh = {r_rem, r_rad[31:30]};
        trial  = {2'b00, r_root, 2'b01};
        sq_ge  = (rem_sh >= trial);
        dlt    = {1'b0, r_root} - {1'b0, r_thresh};
        ysq    = 62'(r_y) * 62'(r_y);
        ysh    = ysq[61:30];
        l2     = {5'(r_k - 6'd16), r_frac};
        lnp    = 37'(l2) * 37'(LN2_Q16) + 37'd32768;
        div_sh = {r_drem, r_q[32]};
        div_ge = (div_sh >= {1'b0, r_dn});
        scp    = 52'(r_ln) * 52'(r_nr);
        sct    = scp[51:16];
        acc_s  = {1'b0, r_sum} + (SUM_W+1)'(r_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= RST_WIDTH;
            r_height    <= RST_HEIGHT;
            r_gain      <= RST_GAIN;
            r_thresh    <= RST_THRESH;
            r_dirty     <= 1'b1;
            r_col       <= '0;
            r_row       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.accept) begin
                r_pix <= i_pixel;
                r_col <= col_in;
                r_row <= row_in;
            end
            if (i_cmd.shift) begin
                for (int i = 0; i < 3; i++) begin
                    r_win[i][0] <= r_win[i][1];
                    r_win[i][1] <= r_win[i][2];
                end
                r_win[0][2] <= up_rd;
                r_win[1][2] <= mid_rd;
                r_win[2][2] <= r_pix;
            end
            if (i_cmd.norm_start) begin
                r_dirty <= 1'b0;
            end
            if (i_cmd.acc) begin
                r_sum <= acc_s[SUM_W] ? SUM_MAX : acc_s[SUM_W-1:0];
            end
            if (i_cmd.advance) begin
                if (frame_end) begin
                    r_out       <= r_sum;
                    r_out_valid <= 1'b1;
                    r_col       <= '0;
                    r_row       <= '0;
                    r_sum       <= '0;
                end else if (col_wrap) begin
                    r_col <= '0;
                    r_row <= r1[11:0];
                end else begin
                    r_col <= c1[CW-1:0];
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_WIDTH: begin
                        r_width <= i_cfg_data[10:0];
                        r_col   <= '0;
                        r_row   <= '0;
                        r_sum   <= '0;
                    end
                    REG_HEIGHT: begin
                        r_height <= i_cfg_data[12:0];
                        r_col    <= '0;
                        r_row    <= '0;
                        r_sum    <= '0;
                    end
                    REG_GAIN: begin
                        r_gain  <= i_cfg_data;
                        r_dirty <= 1'b1;
                    end
                    REG_THRESH: begin
                        r_thresh <= i_cfg_data;
                        r_dirty  <= 1'b1;
                    end
                    default: begin
                        r_dirty <= r_dirty;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.grad) begin
            r_gx2 <= gx2[35:0];
            r_gy2 <= gy2[35:0];
        end
        if (i_cmd.sqrt_init) begin
            r_rad  <= 32'((37'(r_gx2) + 37'(r_gy2)) >> 5);
            r_root <= '0;
            r_rem  <= '0;
        end
        if (i_cmd.sqrt_step) begin
            r_rem  <= sq_ge ? 18'(rem_sh - trial) : rem_sh[17:0];
            r_root <= {r_root[14:0], sq_ge};
            r_rad  <= {r_rad[29:0], 2'b00};
        end
        if (i_cmd.map) begin
            r_v  <= '0;
            r_lx <= 33'(32'(gain_eff) * 32'(dlt[15:0])) + 33'h10000;
            r_k  <= 6'd32;
        end
        if (i_cmd.norm_start) begin
            r_lx <= 33'(33'(gain_eff) * 33'(17'h10000 - {1'b0, r_thresh})) + 33'h10000;
            r_k  <= 6'd32;
        end
        if (i_cmd.ln_norm) begin
            if (!r_lx[32]) begin
                r_lx <= {r_lx[31:0], 1'b0};
                r_k  <= r_k - 6'd1;
            end else begin
                r_y    <= r_lx[32:2];
                r_frac <= '0;
            end
        end
        if (i_cmd.ln_sq) begin
            if (ysh[31]) begin
                r_y    <= ysh[31:1];
                r_frac <= {r_frac[14:0], 1'b1};
            end else begin
                r_y    <= ysh[30:0];
                r_frac <= {r_frac[14:0], 1'b0};
            end
        end
        if (i_cmd.ln_fin) begin
            r_ln <= lnp[35:16];
        end
        if (i_cmd.div_init) begin
            r_dn   <= (r_ln == '0) ? LN_W'(1) : r_ln;
            r_drem <= '0;
            r_q    <= 33'h1_0000_0000;
        end
        if (i_cmd.div_step) begin
            r_drem <= div_ge ? LN_W'(div_sh - {1'b0, r_dn}) : div_sh[LN_W-1:0];
            r_q    <= {r_q[31:0], div_ge};
        end
        if (i_cmd.div_fin) begin
            r_nr <= r_q[32] ? '1 : r_q[31:0];
        end
        if (i_cmd.scale) begin
            r_v <= (sct > 36'(V_MAX)) ? V_MAX : sct[V_W-1:0];
        end
    end

    assign o_stat.eval_mask  = {e0 && col_end && row_end, e0 && row_end, e0 && col_end, e0};
    assign o_stat.below      = (r_root < r_thresh);
    assign o_stat.lx_top     = r_lx[32];
    assign o_stat.norm_dirty = r_dirty;
    assign o_stat.out_free   = !frame_end || !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_quality_sum = r_out;

endmodule

/* rtl/gradient_info_image_metric.sv */
// Top level of the gradient information image metric.
// Takes one frame of 16-bit gray pixels in raster order and returns one saturating
// 38-bit Q22.16 sum of log-mapped Sobel gradient magnitudes after the frame's last
// pixel. Each pixel passes through intake, window update and evaluation scan, plus
// each window evaluation it triggers (0 to 4; 1 for most pixels, more at the
// right and bottom borders), which runs the 16-step square root, the normalizing
// shift of the log argument and the 16-step log squaring loop; a gradient below
// the threshold skips the log. The last pixel of a frame holds in its advance
// state while the previous sum still waits on the output.
// After reset and after every write of the gain or threshold register the block
// keeps o_in_ready low while it recomputes the normalizing reciprocal through
// the same log unit and a 33-step divider. Geometry writes restart the frame.
module gradient_info_image_metric #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [giim_pkg::PIX_W-1:0]  i_pixel,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [giim_pkg::SUM_W-1:0]  o_quality_sum,
    input  logic                        i_cfg_we,
    input  logic [giim_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [giim_pkg::CFG_DW-1:0] i_cfg_data
);

    import giim_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    giim_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    giim_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_pixel       (i_pixel),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_quality_sum (o_quality_sum)
    );

endmodule
